>>> rtl/core/lpht_pkg.sv
package lpht_pkg;

   // request and result payloads
   typedef struct packed {
      logic        func;
      logic [3:0]  key_type;
      logic [63:0] key_value;
      logic [63:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] result_value;
      logic [5:0]  slot_index;
   } rsp_type;

   // one table slot as held in the slot memory
   typedef struct packed {
      logic        valid;
      logic [63:0] hash;
      logic [3:0]  key_type;
      logic [63:0] key_value;
      logic [63:0] value;
   } entry_type;

   // operation codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_SET    = 1'b1;

   // result status codes
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_UPDATED   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_BOOL_TYPE  = 2'd0;
   localparam logic [1:0] CSR_LOAD_LIMIT = 2'd1;

   // register reset values
   localparam logic [3:0] BOOL_TYPE_RESET  = 4'd1;
   localparam logic [6:0] LOAD_LIMIT_RESET = 7'd32;

   // key hash constants
   localparam logic [63:0] HASH_SEED  = 64'd5381;
   localparam int          HASH_SHIFT = 5;

   // remainder unit folds this many hash bits per step
   localparam int MOD_CHUNK_W = 16;

endpackage

>>> rtl/core/linear_probe_hash_table_top.sv
// sequence: the hash remainder (S_MOD), then one probe per slot (S_CMP) until an empty slot,
//    a hit or a full wrap; when TABLE_SLOTS is not a power of two the remainder folds 16 bits per step
// a new request is taken only once the last result is out; busy drops in the strobe cycle
// each probe is one read of the single-port-read slot memory and one compare
// reset: busy stays high while a sweep clears the slot memory
// results cannot be stalled: rsp_valid marks each result for one cycle
module linear_probe_hash_table_top #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lpht_pkg::req_type req_data,
   output logic              rsp_valid,
   output lpht_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_wdata
);

   localparam int IDX_W   = $clog2(TABLE_SLOTS);
   localparam int ENTRY_W = $bits(lpht_pkg::entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_MOD   = 4'b0100,
      S_CMP   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   lpht_pkg::req_type req_ff, req_in;
   logic [63:0]       hash_ff, hash_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  probe_ff, probe_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [6:0]        count_ff, count_in;
   logic [3:0]        bool_type_ff;
   logic [6:0]        load_limit_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic [63:0]         req_hash;
   logic                mod_done;
   logic [IDX_W-1:0]    mod_rem;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   lpht_pkg::entry_type wr_entry;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_raw;
   lpht_pkg::entry_type rd_entry;
   logic                hit;
   logic [IDX_W-1:0]    idx_next;
   logic [IDX_W+5:0]    idx_ext;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // key hash
   always_comb begin
      if (req_data.key_type == bool_type_ff) begin
         req_hash = {63'd0, |req_data.key_value};
      end else begin
         req_hash = (req_data.key_value << lpht_pkg::HASH_SHIFT) + lpht_pkg::HASH_SEED;
      end
   end

   // start slot: hash mod TABLE_SLOTS
   lpht_mod_unit #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .value     (req_hash),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // slot memory
   lpht_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = lpht_pkg::entry_type'(rd_raw);

   // slot compare
   assign hit = rd_entry.valid && (rd_entry.hash == hash_ff) &&
                (rd_entry.key_type == req_ff.key_type) &&
                (rd_entry.key_value == req_ff.key_value);

   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign idx_ext  = {6'd0, idx_ff};

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      hash_in      = hash_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_entry     = '0;
      rd_addr      = idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               hash_in  = req_hash;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            rd_addr = mod_rem;
            if (mod_done) begin
               idx_in   = mod_rem;
               probe_in = '0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            rsp_in.result_value = '0;
            rsp_in.slot_index   = '0;
            rsp_in.status       = (req_ff.func == lpht_pkg::FUNC_SET) ?
                                  lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
            wr_entry.valid      = 1'b1;
            wr_entry.hash       = hash_ff;
            wr_entry.key_type   = req_ff.key_type;
            wr_entry.key_value  = req_ff.key_value;
            wr_entry.value      = req_ff.new_value;
            rd_addr             = idx_next;
            priority if (!rd_entry.valid) begin
               // empty slot ends the run
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (req_ff.func == lpht_pkg::FUNC_SET && count_ff < load_limit_ff) begin
                  wr_en             = 1'b1;
                  count_in          = count_ff + 7'd1;
                  rsp_in.status     = lpht_pkg::ST_INSERTED;
                  rsp_in.slot_index = idx_ext[5:0];
               end
            end else if (hit) begin
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
               rsp_in.slot_index = idx_ext[5:0];
               if (req_ff.func == lpht_pkg::FUNC_SET) begin
                  wr_en         = 1'b1;
                  rsp_in.status = lpht_pkg::ST_UPDATED;
               end else begin
                  rsp_in.status       = lpht_pkg::ST_FOUND;
                  rsp_in.result_value = rd_entry.value;
               end
            end else if (probe_ff == LAST_IDX) begin
               // every slot visited
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_next;
               probe_in = probe_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      hash_ff  <= hash_in;
      idx_ff   <= idx_in;
      probe_ff <= probe_in;
      rsp_ff   <= rsp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bool_type_ff  <= lpht_pkg::BOOL_TYPE_RESET;
         load_limit_ff <= lpht_pkg::LOAD_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lpht_pkg::CSR_BOOL_TYPE:  bool_type_ff  <= csr_wdata[3:0];
            lpht_pkg::CSR_LOAD_LIMIT: load_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a request");

   // results never come back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // an insert bumps the entry count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == lpht_pkg::ST_INSERTED) |->
      (count_ff == 7'($past(count_ff) + 7'd1)))
      else $error("entry count not advanced on insert");

   // misses report zero value and slot
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == lpht_pkg::ST_NOT_FOUND ||
                     rsp_data.status == lpht_pkg::ST_FULL)) |->
      (rsp_data.result_value == 64'd0 && rsp_data.slot_index == 6'd0))
      else $error("miss result carries nonzero value or slot");

endmodule

>>> rtl/core/lpht_ram.sv
module lpht_ram #(
   parameter int WIDTH = 197,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lpht_mod_unit.sv
module lpht_mod_unit #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [63:0]                    value,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] remainder
);

   localparam int  IDX_W = $clog2(TABLE_SLOTS);
   localparam bit  POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic [IDX_W-1:0] rem_ff;
         logic             done_ff;

         // power of two: remainder is the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               rem_ff <= value[IDX_W-1:0];
            end
         end

         assign done      = done_ff;
         assign remainder = rem_ff;
      end else begin : g_recip
         localparam int CHUNK_W = lpht_pkg::MOD_CHUNK_W;
         localparam int STEPS   = 64 / CHUNK_W;
         localparam int CNT_W   = $clog2(STEPS);
         localparam int X_W     = IDX_W + CHUNK_W;
         localparam logic [X_W-1:0] MODULUS = X_W'(TABLE_SLOTS);
         localparam logic [X_W-1:0] RECIP   = X_W'((64'd1 << X_W) / TABLE_SLOTS);

         logic [IDX_W-1:0]   rem_ff, rem_in;
         logic [63:0]        sh_ff, sh_in;
         logic [X_W-1:0]     x_ff, x_in;
         logic [CHUNK_W-1:0] quo_ff, quo_in;
         logic [CNT_W-1:0]   cnt_ff, cnt_in;
         logic               phase_ff, phase_in;
         logic               run_ff, run_in;
         logic               done_ff, done_in;
         logic [X_W-1:0]     chunk_x;
         logic [2*X_W-1:0]   prod;
         logic [X_W-1:0]     back;
         logic [X_W-1:0]     part;
         logic [X_W-1:0]     part_sub;

         // quotient estimate of running remainder and next chunk, low by at most one
         assign chunk_x = {rem_ff, sh_ff[63 -: CHUNK_W]};
         assign prod    = (2 * X_W)'(chunk_x) * (2 * X_W)'(RECIP);

         // multiply back, subtract, one correction step
         assign back     = X_W'(quo_ff) * MODULUS;
         assign part     = x_ff - back;
         assign part_sub = part - MODULUS;

         // chunk sequencing, msb first, a quotient phase then a remainder phase per chunk
         always_comb begin
            rem_in   = rem_ff;
            sh_in    = sh_ff;
            x_in     = x_ff;
            quo_in   = quo_ff;
            cnt_in   = cnt_ff;
            phase_in = phase_ff;
            run_in   = run_ff;
            done_in  = 1'b0;
            if (start) begin
               rem_in   = '0;
               sh_in    = value;
               cnt_in   = '0;
               phase_in = 1'b0;
               run_in   = 1'b1;
            end else if (run_ff && !phase_ff) begin
               x_in     = chunk_x;
               quo_in   = prod[X_W +: CHUNK_W];
               sh_in    = sh_ff << CHUNK_W;
               phase_in = 1'b1;
            end else if (run_ff) begin
               rem_in   = (part >= MODULUS) ? part_sub[IDX_W-1:0] : part[IDX_W-1:0];
               cnt_in   = cnt_ff + CNT_W'(1);
               phase_in = 1'b0;
               if (cnt_ff == CNT_W'(STEPS - 1)) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff   <= 1'b0;
               done_ff  <= 1'b0;
               cnt_ff   <= '0;
               phase_ff <= 1'b0;
            end else begin
               run_ff   <= run_in;
               done_ff  <= done_in;
               cnt_ff   <= cnt_in;
               phase_ff <= phase_in;
            end
            rem_ff <= rem_in;
            sh_ff  <= sh_in;
            x_ff   <= x_in;
            quo_ff <= quo_in;
         end

         assign done      = done_ff;
         assign remainder = rem_ff;
      end
   endgenerate

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int TABLE_SLOTS = 64;
   localparam int STALL_LIMIT = 5000;
   localparam int POOL_SIZE   = 32;

   typedef struct {
      lpht_pkg::req_type req;
      bit                typed;
      lpht_pkg::rsp_type rsp;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   lpht_pkg::req_type req_data;
   logic              rsp_valid;
   lpht_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [6:0]        csr_wdata;

   // table image kept by the testbench
   logic [3:0]  bool_code;
   logic [6:0]  load_limit;
   bit          slot_valid [TABLE_SLOTS];
   logic [63:0] slot_hash  [TABLE_SLOTS];
   logic [3:0]  slot_type  [TABLE_SLOTS];
   logic [63:0] slot_key   [TABLE_SLOTS];
   logic [63:0] slot_value [TABLE_SLOTS];
   logic [6:0]  entry_count;

   // keys that recur so lookups hit and sets update
   logic [3:0]  pool_type [POOL_SIZE];
   logic [63:0] pool_key  [POOL_SIZE];

   lpht_pkg::rsp_type pending_rsp [$];
   directed_row_type  directed_rows [$];
   int                errors;
   int                stall_cycles;

   linear_probe_hash_table_top #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // boolean tags hash to zero or one, everything else shifts and adds the seed
   function automatic logic [63:0] calc_hash(input logic [3:0] kt, input logic [63:0] kv);
      if (kt == bool_code) return {63'd0, kv != 64'd0};
      return (kv << lpht_pkg::HASH_SHIFT) + lpht_pkg::HASH_SEED;
   endfunction

   // walk the probe run, update the table image and return the result
   function automatic lpht_pkg::rsp_type probe_table(input lpht_pkg::req_type r);
      logic [63:0]       h;
      int                idx;
      int                n;
      bit                is_set;
      lpht_pkg::rsp_type res;
      h = calc_hash(r.key_type, r.key_value);
      idx = int'(h % TABLE_SLOTS);
      is_set = (r.func == lpht_pkg::FUNC_SET);
      res.status = is_set ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
      res.result_value = '0;
      res.slot_index = '0;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (!slot_valid[idx]) begin
            if (is_set && entry_count < load_limit) begin
               slot_valid[idx] = 1'b1;
               slot_hash[idx]  = h;
               slot_type[idx]  = r.key_type;
               slot_key[idx]   = r.key_value;
               slot_value[idx] = r.new_value;
               entry_count     = entry_count + 7'd1;
               res.status      = lpht_pkg::ST_INSERTED;
               res.slot_index  = idx[5:0];
            end
            break;
         end
         if (slot_hash[idx] == h && slot_type[idx] == r.key_type &&
             slot_key[idx] == r.key_value) begin
            if (is_set) begin
               slot_value[idx] = r.new_value;
               res.status = lpht_pkg::ST_UPDATED;
            end else begin
               res.status = lpht_pkg::ST_FOUND;
               res.result_value = slot_value[idx];
            end
            res.slot_index = idx[5:0];
            break;
         end
         idx = (idx + 1) % TABLE_SLOTS;
      end
      return res;
   endfunction

   // random word with extra weight on zero, all ones and tiny values
   function automatic logic [63:0] rand_word();
      case ($urandom_range(15))
         0: return 64'd0;
         1: return '1;
         2: return 64'($urandom_range(3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic lpht_pkg::req_type random_request();
      lpht_pkg::req_type r;
      int                pick;
      r.func = $urandom_range(1) ? lpht_pkg::FUNC_SET : lpht_pkg::FUNC_LOOKUP;
      if ($urandom_range(3) != 0) begin
         pick = $urandom_range(POOL_SIZE - 1);
         r.key_type  = pool_type[pick];
         r.key_value = pool_key[pick];
      end else begin
         r.key_type  = 4'($urandom_range(15));
         r.key_value = rand_word();
      end
      r.new_value = rand_word();
      return r;
   endfunction

   // drive one request, wait for it to be taken, queue its expected result
   task automatic send_request(input lpht_pkg::req_type r, input int idle_pct, input bit typed,
                               input lpht_pkg::rsp_type typed_rsp);
      lpht_pkg::rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = probe_table(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pending_rsp.size() != 0 || busy);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == lpht_pkg::CSR_BOOL_TYPE) bool_code = val[3:0];
      else if (idx == lpht_pkg::CSR_LOAD_LIMIT) load_limit = val;
   endtask

   task automatic add_row(input logic f, input logic [3:0] kt, input logic [63:0] kv,
                          input logic [63:0] nv, input bit typed, input logic [2:0] st,
                          input logic [63:0] rv, input logic [5:0] si);
      directed_row_type row;
      row.req.func          = f;
      row.req.key_type      = kt;
      row.req.key_value     = kv;
      row.req.new_value     = nv;
      row.typed             = typed;
      row.rsp.status        = st;
      row.rsp.result_value  = rv;
      row.rsp.slot_index    = si;
      directed_rows.push_back(row);
   endtask

   // one setting of the registers followed by random traffic
   task automatic run_phase(input logic [3:0] code, input logic [6:0] lim, input int idle_pct,
                            input int n_items);
      lpht_pkg::req_type r;
      lpht_pkg::rsp_type none;
      int                sent;
      none = '0;
      sent = 0;
      wait_idle();
      write_csr(lpht_pkg::CSR_BOOL_TYPE, {3'd0, code});
      write_csr(lpht_pkg::CSR_LOAD_LIMIT, lim);
      // with the whole table allowed, fill it so probe runs meet no empty slot
      while (lim == TABLE_SLOTS && entry_count < lim && sent < n_items) begin
         r.func      = lpht_pkg::FUNC_SET;
         r.key_type  = 4'($urandom_range(15));
         r.key_value = {$urandom, $urandom};
         r.new_value = rand_word();
         send_request(r, idle_pct, 1'b0, none);
         sent++;
      end
      while (sent < n_items) begin
         send_request(random_request(), idle_pct, 1'b0, none);
         sent++;
      end
   endtask

   // no activity watchdog
   always_ff @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (stall_cycles < STALL_LIMIT);
      $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // result checker
   always @(posedge clock) begin
      lpht_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.result_value !== want.result_value) begin
               $display("%0t: result_value mismatch, expected %h, got %h",
                        $time, want.result_value, rsp_data.result_value);
               errors++;
            end
            if (rsp_data.slot_index !== want.slot_index) begin
               $display("%0t: slot_index mismatch, expected %0d, got %0d",
                        $time, want.slot_index, rsp_data.slot_index);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int i;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      errors      = 0;
      bool_code   = lpht_pkg::BOOL_TYPE_RESET;
      load_limit  = lpht_pkg::LOAD_LIMIT_RESET;
      entry_count = '0;
      for (i = 0; i < TABLE_SLOTS; i++) slot_valid[i] = 1'b0;

      // key pool: the directed keys first, then random ones
      pool_type[0] = 4'd1;  pool_key[0] = 64'd0;
      pool_type[1] = 4'd1;  pool_key[1] = '1;
      pool_type[2] = 4'd0;  pool_key[2] = 64'd0;
      pool_type[3] = 4'd0;  pool_key[3] = 64'd2;
      pool_type[4] = 4'd2;  pool_key[4] = 64'd0;
      pool_type[5] = 4'd15; pool_key[5] = '1;
      pool_type[6] = 4'd3;  pool_key[6] = 64'd1;
      for (i = 7; i < POOL_SIZE; i++) begin
         pool_type[i] = 4'($urandom_range(15));
         pool_key[i]  = rand_word();
      end

      // directed rows, table empty and registers at reset values
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd1, 64'd0, '1, 1'b1,
              lpht_pkg::ST_NOT_FOUND, 64'd0, 6'd0);
      add_row(lpht_pkg::FUNC_SET, 4'd1, 64'd0, '1, 1'b1,
              lpht_pkg::ST_INSERTED, 64'd0, 6'd0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd1, 64'd0, 64'd0, 1'b1,
              lpht_pkg::ST_FOUND, '1, 6'd0);
      add_row(lpht_pkg::FUNC_SET, 4'd1, 64'd0, 64'h0123_4567_89ab_cdef, 1'b1,
              lpht_pkg::ST_UPDATED, 64'd0, 6'd0);
      add_row(lpht_pkg::FUNC_SET, 4'd1, '1, 64'd0, 1'b1,
              lpht_pkg::ST_INSERTED, 64'd0, 6'd1);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd1, '1, '1, 1'b1,
              lpht_pkg::ST_FOUND, 64'd0, 6'd1);
      // boolean key that shares hash one with a different stored key
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd1, 64'd5, 64'd0, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd1, 64'h8000_0000_0000_0000, 64'd0, 1'b0, '0, '0, '0);
      // ordinary hashes, collisions by key and by type
      add_row(lpht_pkg::FUNC_SET, 4'd0, 64'd0, 64'hdead_beef_0000_0001, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_SET, 4'd15, '1, '1, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_SET, 4'd0, 64'd2, 64'h5555_aaaa_5555_aaaa, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_SET, 4'd2, 64'd0, 64'haaaa_5555_aaaa_5555, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd2, 64'd0, 64'd0, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd0, 64'd2, 64'd0, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd0, 64'd4, '1, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_SET, 4'd3, 64'd1, 64'd7, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd15, '1, 64'd0, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd3, 64'd1, 64'd0, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_SET, 4'd15, '1, 64'd0, 1'b0, '0, '0, '0);
      add_row(lpht_pkg::FUNC_LOOKUP, 4'd15, '1, 64'd0, 1'b0, '0, '0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++)
         send_request(directed_rows[i].req, 0, directed_rows[i].typed, directed_rows[i].rsp);

      // reset values, no idling
      run_phase(lpht_pkg::BOOL_TYPE_RESET, lpht_pkg::LOAD_LIMIT_RESET, 0, 150);
      // limit zero: every new key refused, boolean tag moved
      run_phase(4'd0, 7'd0, 67, 80);
      // limit below the entry count, highest tag
      run_phase(4'd15, 7'd10, 0, 80);
      // whole table allowed and filled, then probing over a full table
      run_phase(4'd7, 7'd64, 38, 190);

      wait_idle();
      repeat (TABLE_SLOTS + 4) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
